[rtl/rdsm_pkg.sv]
package rdsm_pkg;

  localparam int MAX_PAT_DEF = 32;

  localparam logic [7:0] STAR_CHAR = 8'd42;
  localparam logic [7:0] DOT_CHAR  = 8'd46;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_START  = 2'd2,
    REQ_TEXT   = 2'd3
  } req_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic       adv;
    logic       ge2;
    logic [7:0] pat;
    logic [7:0] pat_prev;
    logic [7:0] text;
    logic       old_prev;
    logic       row_j;
    logic       row_jm2;
  } col_in_t;

endpackage

[rtl/rdsm_pat_mem.sv]
module rdsm_pat_mem #(
  parameter int DEPTH = rdsm_pkg::MAX_PAT_DEF,
  parameter int AW    = $clog2(rdsm_pkg::MAX_PAT_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  import rdsm_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/rdsm_col_unit.sv]
module rdsm_col_unit (
  input  rdsm_pkg::col_in_t col_in,
  output logic              col_bit
);
  import rdsm_pkg::*;

  logic fits_pat;
  logic fits_prev;

  assign fits_pat  = (col_in.pat == DOT_CHAR) || (col_in.pat == col_in.text);
  assign fits_prev = (col_in.pat_prev == DOT_CHAR) || (col_in.pat_prev == col_in.text);

  always_comb begin
    if (!col_in.adv) begin
      col_bit = (col_in.pat == STAR_CHAR) && col_in.ge2 && col_in.row_jm2;
    end else if (col_in.pat != STAR_CHAR) begin
      col_bit = col_in.old_prev && fits_pat;
    end else if (col_in.ge2) begin
      col_bit = col_in.row_jm2 || (col_in.row_j && fits_prev);
    end else begin
      col_bit = 1'b0;
    end
  end

endmodule

[rtl/regex_dot_star_matcher.sv]
// channel | handshake            | payload
// input   | in_valid / in_stall  | req_type, char_value
// output  | out_valid / out_stall| matched
//
// Each item walks the pattern, and the block takes no new item while busy:
// the row is updated one column per cycle through the single read port of
// the pattern memory. Reset clears the pattern length and the row; the
// pattern memory is not cleared. A stalled result holds the block busy
// until the output register frees.
module regex_dot_star_matcher #(
  parameter int MAX_PAT = rdsm_pkg::MAX_PAT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] char_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched
);
  import rdsm_pkg::*;

  localparam int AW = $clog2(MAX_PAT);
  localparam int LW = $clog2(MAX_PAT + 1);

  state_t          state;
  state_t          state_next;
  logic [LW-1:0]   pat_len;
  logic [MAX_PAT:0] row;
  logic [LW-1:0]   iss;
  logic [LW-1:0]   col;
  logic            col_valid;
  logic            adv_mode;
  logic            want_result;
  logic [7:0]      text_char;
  logic            old_prev;
  logic [7:0]      prev_char;

  req_t            req;
  logic            accept;
  logic            issue;
  logic            run_done;
  logic            out_free;
  logic            pat_full;
  logic            wr_en;
  logic [7:0]      rd_data;
  logic            ge2;
  logic [LW-1:0]   jm2;
  col_in_t         col_in;
  logic            col_bit;

  assign req      = req_t'(req_type);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign pat_full = (pat_len >= LW'(MAX_PAT));
  assign wr_en    = accept && (req == REQ_APPEND) && !pat_full;
  assign issue    = (state == S_RUN) && (iss < pat_len);
  assign run_done = (state == S_RUN) && !issue && !col_valid;
  assign out_free = !out_valid || !out_stall;
  assign ge2      = (col >= LW'(2));
  assign jm2      = ge2 ? (col - LW'(2)) : '0;

  rdsm_pat_mem #(
    .DEPTH (MAX_PAT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pat_len[AW-1:0]),
    .wr_data (char_value),
    .rd_addr (iss[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    col_in.adv      = adv_mode;
    col_in.ge2      = ge2;
    col_in.pat      = rd_data;
    col_in.pat_prev = prev_char;
    col_in.text     = text_char;
    col_in.old_prev = old_prev;
    col_in.row_j    = row[col];
    col_in.row_jm2  = row[jm2];
  end

  rdsm_col_unit u_col (
    .col_in  (col_in),
    .col_bit (col_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (run_done && (!want_result || out_free)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len   <= '0;
      row       <= {{MAX_PAT{1'b0}}, 1'b1};
      out_valid <= 1'b0;
      col_valid <= 1'b0;
      iss       <= '0;
    end else begin
      if (out_valid && !out_stall && !(run_done && want_result)) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        iss         <= '0;
        col_valid   <= 1'b0;
        text_char   <= char_value;
        adv_mode    <= (req == REQ_TEXT);
        want_result <= (req == REQ_START) || (req == REQ_TEXT);
        old_prev    <= row[0];
        case (req)
          REQ_CLEAR: begin
            pat_len <= '0;
            row     <= {{MAX_PAT{1'b0}}, 1'b1};
          end
          REQ_APPEND: begin
            if (!pat_full) begin
              pat_len <= pat_len + LW'(1);
            end
            row <= {{MAX_PAT{1'b0}}, 1'b1};
          end
          REQ_START: begin
            row <= {{MAX_PAT{1'b0}}, 1'b1};
          end
          REQ_TEXT: begin
            row[0] <= 1'b0;
          end
          default: row <= row;
        endcase
      end
      if (state == S_RUN) begin
        col_valid <= issue;
        if (issue) begin
          iss <= iss + LW'(1);
          col <= iss + LW'(1);
        end
        if (col_valid) begin
          row[col]  <= col_bit;
          old_prev  <= row[col];
          prev_char <= rd_data;
        end
        if (run_done && want_result && out_free) begin
          out_valid <= 1'b1;
          matched   <= row[pat_len];
        end
      end
    end
  end

endmodule

[rtl/rdsm_checker.sv]
module rdsm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic matched
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(matched))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block ready straight after taking an item");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind regex_dot_star_matcher rdsm_checker u_rdsm_checker (.*);
